/* hdl/rrts_pkg.sv */
// Shared constants, codes and types of the round-robin task scheduler.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package rrts_pkg;

  localparam int IdW         = 4;
  localparam int NumIds      = 16;
  localparam int OpW         = 3;
  localparam int StW         = 2;
  localparam int SliceW      = 16;
  localparam int CountW      = 5;
  localparam int MaxTasksDef = 16;

  localparam logic [SliceW-1:0] SliceReset = 16'd10;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SET    = 3'd3,
    OP_START  = 3'd4
  } opcode_t;

  typedef enum logic [StW-1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_ZOMBIE  = 2'd3
  } task_state_t;

  // Operations broadcast to the queue cell row.
  typedef enum logic [2:0] {
    Q_HOLD,
    Q_ROTATE,
    Q_DROP,
    Q_PUSH,
    Q_MARK
  } qop_t;

  // Contents of one queue cell: a task id and a copy of "that task is ready".
  typedef struct packed {
    logic [IdW-1:0] id;
    logic           rdy;
  } cell_t;

  typedef struct packed {
    qop_t           op;
    logic [IdW-1:0] id;
    logic           rdy;
  } qcmd_t;

endpackage

`default_nettype wire

/* hdl/rrts_intf.sv */
// Handshake channels of the scheduler: command, result and configuration.
// Depends on rrts_pkg for the field widths.
`default_nettype none

interface rrts_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [rrts_pkg::OpW-1:0]   opcode;
  logic [rrts_pkg::IdW-1:0]   task_id;
  logic [rrts_pkg::StW-1:0]   task_state;

  modport source (output valid, opcode, task_id, task_state, input ready);
  modport sink   (input valid, opcode, task_id, task_state, output ready);
endinterface

interface rrts_res_if;
  logic                         valid;
  logic                         ready;
  logic                         switched;
  logic [rrts_pkg::IdW-1:0]     running_task;
  logic                         running_valid;
  logic                         queue_overflow;
  logic [rrts_pkg::CountW-1:0]  queue_count;

  modport source (output valid, switched, running_task, running_valid, queue_overflow,
                  queue_count, input ready);
  modport sink   (input valid, switched, running_task, running_valid, queue_overflow,
                  queue_count, output ready);
endinterface

interface rrts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrts_pkg::SliceW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/rrts_cell.sv */
// One cell of the ready queue row: holds one task id and its ready flag.
// Depends on rrts_pkg for the cell and command types.
`default_nettype none

module rrts_cell (
  input  logic            clk,
  input  rrts_pkg::qcmd_t cmd,
  input  logic            is_tail,
  input  logic            is_push,
  input  rrts_pkg::cell_t right,
  input  rrts_pkg::cell_t head,
  output rrts_pkg::cell_t q
);

  always_ff @(posedge clk) begin
    case (cmd.op)
      rrts_pkg::Q_ROTATE: begin
        // The last live cell takes the head entry back, closing the ring.
        if (is_tail) begin
          q <= head;
        end else begin
          q <= right;
        end
      end
      rrts_pkg::Q_DROP: begin
        q <= right;
      end
      rrts_pkg::Q_PUSH: begin
        if (is_push) begin
          q.id  <= cmd.id;
          q.rdy <= cmd.rdy;
        end else if (q.id == cmd.id) begin
          q.rdy <= cmd.rdy;
        end
      end
      rrts_pkg::Q_MARK: begin
        if (q.id == cmd.id) begin
          q.rdy <= cmd.rdy;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/rrts_queue.sv */
// Ready queue built as a row of rrts_cell; cell 0 is the head of the queue.
// Depends on rrts_pkg and rrts_cell.
`default_nettype none

module rrts_queue #(
  parameter int MAX_TASKS = rrts_pkg::MaxTasksDef
) (
  input  logic                             clk,
  input  rrts_pkg::qcmd_t                  cmd,
  input  logic [$clog2(MAX_TASKS+1)-1:0]   len,
  output rrts_pkg::cell_t                  head
);

  localparam int LenW = $clog2(MAX_TASKS + 1);

  rrts_pkg::cell_t cells [MAX_TASKS];

  assign head = cells[0];

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    rrts_pkg::cell_t right;
    logic            is_tail;
    logic            is_push;

    if (i == MAX_TASKS - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid
      assign right = cells[i+1];
    end

    assign is_tail = (len == LenW'(i + 1));
    assign is_push = (len == LenW'(i));

    rrts_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .is_tail (is_tail),
      .is_push (is_push),
      .right   (right),
      .head    (cells[0]),
      .q       (cells[i])
    );
  end

endmodule

`default_nettype wire

/* hdl/round_robin_task_scheduler.sv */
// Round-robin task scheduler with a time slice per task: control, task tables.
// Depends on rrts_pkg, rrts_intf and rrts_queue.
//
// The scheduler takes one command beat at a time and returns exactly one result
// beat for it. Add, set state, unused opcodes and a tick while nothing runs go
// from the execute state to the finish state, and a tick that only counts down
// passes through the slice state between them; the result register is loaded in
// the finish state. Start, remove and a tick that ends a slice search the ready
// queue by rotating its live entries once through its head cell, one entry per
// cycle. A stalled result channel holds the finish state until the previous
// result is taken. A new command is accepted while the previous result still
// waits on the result channel. The slice length register is written through
// the cfg channel, which is always ready, and should only be written while
// the block is idle. There is no clearing pass after reset.
`default_nettype none

module round_robin_task_scheduler #(
  parameter int MAX_TASKS = rrts_pkg::MaxTasksDef
) (
  input  logic        clk,
  input  logic        rst,
  rrts_cmd_if.sink    cmd,
  rrts_res_if.source  result,
  rrts_cfg_if.sink    cfg
);

  localparam int LenW   = $clog2(MAX_TASKS + 1);
  localparam int IdW    = rrts_pkg::IdW;
  localparam int StW    = rrts_pkg::StW;
  localparam int SliceW = rrts_pkg::SliceW;
  localparam int CountW = rrts_pkg::CountW;
  localparam int NumIds = rrts_pkg::NumIds;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SLICE,
    S_SCAN,
    S_POST,
    S_DISPATCH,
    S_FINISH
  } state_t;

  state_t               state;
  rrts_pkg::opcode_t    op_r;
  logic [IdW-1:0]       id_r;
  logic [StW-1:0]       st_r;
  logic [SliceW-1:0]    slice_length;
  logic [StW-1:0]       task_state [NumIds];
  logic [SliceW-1:0]    slice_left [NumIds];
  logic [LenW-1:0]      len;
  logic [LenW-1:0]      steps;
  logic [IdW-1:0]       cur;
  logic                 cur_valid;
  logic                 sched_en;
  logic                 found;
  logic [IdW-1:0]       nxt;
  logic                 switched;
  logic                 overflow;

  logic                 out_valid;
  logic                 out_switched;
  logic [IdW-1:0]       out_task;
  logic                 out_running;
  logic                 out_overflow;
  logic [CountW-1:0]    out_count;

  rrts_pkg::qcmd_t      qcmd;
  rrts_pkg::cell_t      head;
  logic [IdW-1:0]       st_raddr;
  logic [StW-1:0]       st_rd;
  logic [SliceW-1:0]    slice_rd;
  logic                 id_ok;
  logic                 full;
  logic                 match;

  rrts_queue #(.MAX_TASKS(MAX_TASKS)) u_queue (
    .clk  (clk),
    .cmd  (qcmd),
    .len  (len),
    .head (head)
  );

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign result.valid          = out_valid;
  assign result.switched       = out_switched;
  assign result.running_task   = out_task;
  assign result.running_valid  = out_running;
  assign result.queue_overflow = out_overflow;
  assign result.queue_count    = out_count;

  assign st_raddr = (state == S_POST) ? cur : id_r;
  assign st_rd    = task_state[st_raddr];
  assign slice_rd = slice_left[cur];
  assign id_ok    = (32'(id_r) < 32'(MAX_TASKS));
  assign full     = (len == LenW'(MAX_TASKS));

  // Only the first hit of a scan counts; later head entries just rotate.
  assign match = !found &&
                 ((op_r == rrts_pkg::OP_REMOVE) ? (head.id == id_r) : head.rdy);

  always_comb begin
    qcmd.op  = rrts_pkg::Q_HOLD;
    qcmd.id  = id_r;
    qcmd.rdy = 1'b0;
    case (state)
      S_EXEC: begin
        if (op_r == rrts_pkg::OP_ADD && id_ok && !full) begin
          qcmd.op  = rrts_pkg::Q_PUSH;
          qcmd.rdy = (st_rd == rrts_pkg::ST_READY);
        end else if (op_r == rrts_pkg::OP_SET && id_ok) begin
          qcmd.op  = rrts_pkg::Q_MARK;
          qcmd.rdy = (st_r == rrts_pkg::ST_READY);
        end
      end
      S_SCAN: begin
        if (steps != '0) begin
          qcmd.op = match ? rrts_pkg::Q_DROP : rrts_pkg::Q_ROTATE;
        end
      end
      S_POST: begin
        if (op_r == rrts_pkg::OP_TICK && nxt != cur && st_rd == rrts_pkg::ST_RUNNING) begin
          qcmd.op  = rrts_pkg::Q_PUSH;
          qcmd.id  = cur;
          qcmd.rdy = 1'b1;
        end
      end
      S_DISPATCH: begin
        qcmd.op = rrts_pkg::Q_MARK;
        qcmd.id = nxt;
      end
      default: begin
        qcmd.op = rrts_pkg::Q_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slice_length <= rrts_pkg::SliceReset;
      len          <= '0;
      cur          <= '0;
      cur_valid    <= 1'b0;
      sched_en     <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < NumIds; i++) begin
        task_state[i] <= rrts_pkg::ST_BLOCKED;
        slice_left[i] <= rrts_pkg::SliceReset;
      end
    end else begin
      if (cfg.valid) begin
        slice_length <= cfg.data;
      end
      // In S_FINISH the output register is reloaded below instead.
      if (out_valid && result.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_r     <= rrts_pkg::opcode_t'(cmd.opcode);
            id_r     <= cmd.task_id;
            st_r     <= cmd.task_state;
            switched <= 1'b0;
            overflow <= 1'b0;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          found <= 1'b0;
          steps <= len;
          case (op_r)
            rrts_pkg::OP_TICK: begin
              state <= (sched_en && cur_valid) ? S_SLICE : S_FINISH;
            end
            rrts_pkg::OP_ADD: begin
              if (id_ok) begin
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  len <= len + LenW'(1);
                end
              end
              state <= S_FINISH;
            end
            rrts_pkg::OP_REMOVE: begin
              state <= id_ok ? S_SCAN : S_FINISH;
            end
            rrts_pkg::OP_SET: begin
              if (id_ok) begin
                task_state[id_r] <= st_r;
              end
              state <= S_FINISH;
            end
            rrts_pkg::OP_START: begin
              sched_en <= 1'b1;
              state    <= S_SCAN;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end

        S_SLICE: begin
          // A slice of zero or one runs out on this tick.
          if (slice_rd > SliceW'(1)) begin
            slice_left[cur] <= slice_rd - SliceW'(1);
            state           <= S_FINISH;
          end else begin
            slice_left[cur] <= slice_length;
            state           <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (steps == '0) begin
            state <= found ? S_POST : S_FINISH;
          end else begin
            steps <= steps - LenW'(1);
            if (match) begin
              found <= 1'b1;
              nxt   <= head.id;
              len   <= len - LenW'(1);
            end
          end
        end

        S_POST: begin
          case (op_r)
            rrts_pkg::OP_TICK: begin
              if (nxt == cur) begin
                state <= S_FINISH;
              end else begin
                if (st_rd == rrts_pkg::ST_RUNNING) begin
                  task_state[cur] <= rrts_pkg::ST_READY;
                  len             <= len + LenW'(1);
                end
                state <= S_DISPATCH;
              end
            end
            rrts_pkg::OP_START: begin
              state <= S_DISPATCH;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end

        S_DISPATCH: begin
          task_state[nxt] <= rrts_pkg::ST_RUNNING;
          cur             <= nxt;
          cur_valid       <= 1'b1;
          switched        <= 1'b1;
          state           <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid    <= 1'b1;
            out_switched <= switched;
            out_task     <= cur;
            out_running  <= cur_valid;
            out_overflow <= overflow;
            out_count    <= CountW'(len);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/rrts_checker.sv */
// Port-level checks of the round-robin task scheduler, bound to its top level.
// Depends on round_robin_task_scheduler and the channel interfaces it uses.
`default_nettype none

module rrts_checker #(
  parameter int MAX_TASKS = rrts_pkg::MaxTasksDef
) (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_switched,
  input logic [3:0] res_running_task,
  input logic       res_running_valid,
  input logic       res_overflow,
  input logic [4:0] res_count
);

  logic       cmd_beat;
  logic       res_beat;
  logic [1:0] outstanding;
  logic [4:0] last_count;
  logic [4:0] count_step;

  assign cmd_beat   = cmd_valid && cmd_ready;
  assign res_beat   = res_valid && res_ready;
  assign count_step = res_count - last_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
      last_count  <= 5'd0;
    end else begin
      outstanding <= outstanding + 2'(cmd_beat) - 2'(res_beat);
      if (res_beat) begin
        last_count <= res_count;
      end
    end
  end

  // A waiting result beat holds still until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_switched, res_running_task, res_running_valid, res_overflow, res_count}))
    else $error("result beat changed while stalled");

  // Every result beat answers a command beat that has not been answered yet.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    res_beat |-> outstanding != 2'd0)
    else $error("result beat without an open command");

  // At most one command in work and one result waiting.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("too many commands in flight");

  // No single command moves the queue length by more than one entry.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    res_beat |-> (count_step == 5'd0 || count_step == 5'd1 || count_step == 5'd31))
    else $error("queue count jumped by more than one");

  // An overflow only happens on a full queue and never with a task switch.
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_overflow |-> res_count == 5'(MAX_TASKS) && !res_switched)
    else $error("overflow reported on a queue that is not full");

endmodule

bind round_robin_task_scheduler rrts_checker #(.MAX_TASKS(MAX_TASKS)) u_rrts_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_switched      (result.switched),
  .res_running_task  (result.running_task),
  .res_running_valid (result.running_valid),
  .res_overflow      (result.queue_overflow),
  .res_count         (result.queue_count)
);

`default_nettype wire

/* tb/sched_checker.sv */
// Checker for the round-robin task scheduler: follows the cfg and command channels,
// predicts the result of each command beat and compares it with the result beats.
// Depends on rrts_pkg and the channel interfaces in rrts_intf.
module sched_checker (
  input  logic clk,
  input  logic rst,
  rrts_cmd_if  cmd,
  rrts_res_if  result,
  rrts_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   switches_seen,
  output int   overflows_seen
);
  import rrts_pkg::*;

  typedef struct packed {
    logic              switched;
    logic [IdW-1:0]    task_id;
    logic              task_valid;
    logic              overflow;
    logic [CountW-1:0] count;
  } sched_report_t;

  logic [SliceW-1:0] slice_len;
  logic [IdW-1:0]    ready_fifo[$];
  task_state_t       state_tab[NumIds];
  logic [SliceW-1:0] slice_cnt[NumIds];
  logic [IdW-1:0]    run_id;
  logic              run_valid;
  logic              sched_on;
  sched_report_t     due_reports[$];

  // Pulls the first entry whose task is ready out of the queue.
  function automatic bit take_first_ready(output logic [IdW-1:0] id);
    id = '0;
    for (int i = 0; i < ready_fifo.size(); i++) begin
      if (state_tab[ready_fifo[i]] == ST_READY) begin
        id = ready_fifo[i];
        ready_fifo.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void run_task(logic [IdW-1:0] id);
    run_id = id;
    run_valid = 1'b1;
    state_tab[id] = ST_RUNNING;
  endfunction

  function automatic sched_report_t schedule_command(logic [OpW-1:0] op, logic [IdW-1:0] id,
                                                     logic [StW-1:0] st);
    sched_report_t  r;
    logic [IdW-1:0] nxt;
    logic [IdW-1:0] cur;
    r = '0;
    case (op)
      OP_TICK: begin
        if (sched_on && run_valid) begin
          cur = run_id;
          if (slice_cnt[cur] != 0) slice_cnt[cur] = slice_cnt[cur] - 1'b1;
          if (slice_cnt[cur] == 0) begin
            slice_cnt[cur] = slice_len;
            // The running task itself may be taken; it then stays out of the queue.
            if (take_first_ready(nxt) && nxt != cur) begin
              if (state_tab[cur] == ST_RUNNING) begin
                state_tab[cur] = ST_READY;
                ready_fifo.push_back(cur);
              end
              run_task(nxt);
              r.switched = 1'b1;
            end
          end
        end
      end
      OP_ADD: begin
        if (ready_fifo.size() >= MaxTasksDef) r.overflow = 1'b1;
        else ready_fifo.push_back(id);
      end
      OP_REMOVE: begin
        for (int i = 0; i < ready_fifo.size(); i++) begin
          if (ready_fifo[i] == id) begin
            ready_fifo.delete(i);
            break;
          end
        end
      end
      OP_SET: state_tab[id] = task_state_t'(st);
      OP_START: begin
        sched_on = 1'b1;
        if (take_first_ready(nxt)) begin
          run_task(nxt);
          r.switched = 1'b1;
        end
      end
      default: ;
    endcase
    r.task_id = run_id;
    r.task_valid = run_valid;
    r.count = CountW'(ready_fifo.size());
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sched_report_t want;
    sched_report_t got;
    if (rst) begin
      slice_len = SliceReset;
      ready_fifo.delete();
      due_reports.delete();
      for (int i = 0; i < NumIds; i++) begin
        state_tab[i] = ST_BLOCKED;
        slice_cnt[i] = SliceReset;
      end
      run_id = '0;
      run_valid = 1'b0;
      sched_on = 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) slice_len = cfg.data;
      if (cmd.valid && cmd.ready)
        due_reports.push_back(schedule_command(cmd.opcode, cmd.task_id, cmd.task_state));
      if (result.valid && result.ready) begin
        got = '{result.switched, result.running_task, result.running_valid,
                result.queue_overflow, result.queue_count};
        results_seen++;
        if (got.switched) switches_seen++;
        if (got.overflow) overflows_seen++;
        if (due_reports.size() == 0) begin
          $display("%0t: result beat with none expected, actual %h", $time, got);
          fail_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("switched", want.switched, got.switched);
          check_field("running_task", want.task_id, got.task_id);
          check_field("running_valid", want.task_valid, got.task_valid);
          check_field("queue_overflow", want.overflow, got.overflow);
          check_field("queue_count", want.count, got.count);
        end
      end
    end
    pending <= due_reports.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the scheduler testbench: clock, reset, command and cfg stimulus, result
// back-pressure and the verdict. Depends on rrts_pkg, rrts_intf, the scheduler
// and sched_checker.
module testbench;
  import rrts_pkg::*;

  localparam int CycleLimit    = 500_000;
  localparam int SettleCycles  = 30;
  localparam int HoldCycles    = 300;
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 260;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   hold_reqs = 0;
  int   burst_left = 0;
  int   items_sent = 0;
  int   fails, pending, results_seen, switches_seen, overflows_seen;

  rrts_cmd_if cmd_ch ();
  rrts_res_if res_ch ();
  rrts_cfg_if cfg_ch ();

  round_robin_task_scheduler dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  sched_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .result         (res_ch),
    .cfg            (cfg_ch),
    .fail_count     (fails),
    .pending        (pending),
    .results_seen   (results_seen),
    .switches_seen  (switches_seen),
    .overflows_seen (overflows_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: stall patterns that change at random, plus a long hold-off
  // whenever the command side asks for one.
  initial begin : result_drain
    int hold_left = 0;
    int hold_seen = 0;
    int mode = 0;
    int mode_left = 0;
    int drain_cycles = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      drain_cycles++;
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 1) != 0);
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= drain_cycles[3];
        endcase
      end
    end
  end

  // Offers one command beat and returns at the edge where it is taken. Beats go
  // out in bursts; a gap may open before a new burst.
  task automatic send_cmd(logic [OpW-1:0] op, logic [IdW-1:0] id, logic [StW-1:0] st);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 9) < 7) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.opcode     <= op;
    cmd_ch.task_id    <= id;
    cmd_ch.task_state <= st;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  // The slice length is only written once every result has come back.
  task automatic write_slice(logic [SliceW-1:0] len);
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_cmd(int add_w);
    int             pick;
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    logic [StW-1:0] st;
    pick = $urandom_range(0, 99);
    id = IdW'($urandom_range(0, NumIds - 1));
    st = ($urandom_range(0, 1) != 0) ? ST_READY : StW'($urandom_range(0, 3));
    if (pick < 40) op = OP_TICK;
    else if (pick < 40 + add_w) op = OP_ADD;
    else if (pick < 52 + add_w) op = OP_REMOVE;
    else if (pick < 88) op = OP_SET;
    else if (pick < 95) op = OP_START;
    else op = OpW'($urandom_range(OP_START + 1, (1 << OpW) - 1));
    // Half the adds come with the task made ready first, so it can be dispatched.
    if (op == OP_ADD && $urandom_range(0, 1) != 0) send_cmd(OP_SET, id, ST_READY);
    send_cmd(op, id, st);
  endtask

  initial begin
    logic [SliceW-1:0] phase_slice [NumPhases] =
      '{16'd10, 16'd1, 16'd3, 16'hFFFF, 16'd0, 16'd2, 16'd5};
    int target;
    int add_w;
    bit held;
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.opcode     <= OP_TICK;
    cmd_ch.task_id    <= '0;
    cmd_ch.task_state <= ST_READY;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_slice(16'd1);
    // Directed: idle tick, start with nothing ready, unused opcodes, duplicates
    // in the queue, removal of an absent id and of the first of two, and a start
    // while a task already runs.
    send_cmd(OP_TICK, 4'd0, ST_READY);
    send_cmd(OP_START, 4'd0, ST_READY);
    send_cmd(OpW'(OP_START + 1), 4'd15, ST_ZOMBIE);
    send_cmd(OpW'((1 << OpW) - 1), 4'd0, ST_READY);
    send_cmd(OP_SET, 4'd0, ST_READY);
    send_cmd(OP_SET, 4'd15, ST_READY);
    send_cmd(OP_ADD, 4'd0, ST_READY);
    send_cmd(OP_ADD, 4'd15, ST_READY);
    send_cmd(OP_ADD, 4'd15, ST_READY);
    send_cmd(OP_ADD, 4'd3, ST_READY);
    send_cmd(OP_REMOVE, 4'd9, ST_READY);
    send_cmd(OP_REMOVE, 4'd15, ST_READY);
    send_cmd(OP_TICK, 4'd0, ST_READY);
    send_cmd(OP_START, 4'd0, ST_READY);
    send_cmd(OP_TICK, 4'd0, ST_READY);
    send_cmd(OP_START, 4'd0, ST_READY);
    send_cmd(OP_SET, 4'd3, ST_RUNNING);
    send_cmd(OP_SET, 4'd15, ST_ZOMBIE);
    send_cmd(OP_SET, 4'd0, ST_BLOCKED);
    send_cmd(OP_SET, 4'd0, ST_READY);
    send_cmd(OP_ADD, 4'd0, ST_READY);
    send_cmd(OP_TICK, 4'd0, ST_READY);

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) phase_slice[p] = SliceW'($urandom_range(4, 40));
      write_slice(phase_slice[p]);
      add_w = (p % 3 == 0) ? 35 : (p % 3 == 1) ? 12 : 22;
      target = items_sent + ItemsPerPhase;
      held = 1'b0;
      while (items_sent < target) begin
        // The sender keeps offering beats through the long result hold-off.
        if ((p == 1 || p == 4) && !held && items_sent >= target - ItemsPerPhase + 60) begin
          hold_reqs <= hold_reqs + 1;
          held = 1'b1;
        end
        send_random_cmd(add_w);
      end
    end

    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d command beats over %0d slice settings; %0d results checked,",
             items_sent, NumPhases + 1, results_seen);
    $display("with %0d task switches and %0d queue overflows among them.",
             switches_seen, overflows_seen);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
